### rtl/srb_pkg.sv
`default_nettype none

package srb_pkg;

	localparam int DEPTH       = 32;
	localparam int MAX_RESULTS = 32;
	localparam int VAL_W       = 16;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int REL_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_CHECK = 2'b10
	} srb_state_t;

	typedef struct packed {
		logic insert;
		logic release_head;
		logic emit;
		logic last;
	} srb_cmd_t;

	typedef struct packed {
		logic full;
		logic head_match;
		logic next_match;
		logic out_free;
	} srb_status_t;

endpackage

`default_nettype wire

### rtl/srb_datapath.sv
`default_nettype none

module srb_datapath
	import srb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire srb_cmd_t         cmd,
	output srb_status_t           st,
	input  wire logic [VAL_W-1:0] value,
	input  wire logic             cfg_we,
	input  wire logic [VAL_W-1:0] start_value,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output logic [VAL_W-1:0]      released,
	output logic                  release_valid,
	output logic                  dropped,
	output logic                  last
);

	logic [VAL_W-1:0] store_q [DEPTH];
	logic [CNT_W-1:0] fill_q;
	logic [VAL_W-1:0] expected_q;
	logic             drop_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] released_q;
	logic             release_valid_q;
	logic             dropped_q;
	logic             last_q;

	logic [DEPTH-1:0] ge;
	logic [VAL_W-1:0] expected_dec;

	assign expected_dec = expected_q - VAL_W'(1);

	// entries at or above the new value form a prefix of the store
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (CNT_W'(i) < fill_q) && (store_q[i] >= value);
		end
	end

	assign st.full       = (fill_q == CNT_W'(DEPTH));
	assign st.head_match = (fill_q != '0) && (store_q[0] == expected_q);
	assign st.out_free   = !out_valid_q || !out_stall;

	generate
		if (DEPTH > 1) begin : g_next
			assign st.next_match = (fill_q > CNT_W'(1)) && (store_q[1] == expected_dec);
		end else begin : g_no_next
			assign st.next_match = 1'b0;
		end
	endgenerate

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.insert && !st.full) begin
				if (!ge[i]) begin
					if (i == 0) begin
						store_q[i] <= value;
					end else if (ge[i-1]) begin
						store_q[i] <= value;
					end else begin
						store_q[i] <= store_q[i-1];
					end
				end
			end else if (cmd.release_head && (i < DEPTH - 1)) begin
				store_q[i] <= store_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			expected_q <= '0;
			drop_q     <= 1'b0;
		end else begin
			if (cmd.insert) begin
				drop_q <= st.full;
				if (!st.full) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end else if (cmd.release_head) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (cfg_we) begin
				expected_q <= start_value;
			end else if (cmd.release_head) begin
				expected_q <= expected_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the beat while the receiver stalls
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			released_q      <= cmd.release_head ? store_q[0] : '0;
			release_valid_q <= cmd.release_head;
			dropped_q       <= drop_q;
			last_q          <= cmd.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign released      = released_q;
	assign release_valid = release_valid_q;
	assign dropped       = dropped_q;
	assign last          = last_q;

endmodule

`default_nettype wire

### rtl/srb_controller.sv
`default_nettype none

module srb_controller
	import srb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire srb_status_t st,
	output srb_cmd_t         cmd
);

	srb_state_t       state_q;
	srb_state_t       state_d;
	logic [REL_W-1:0] count_q;
	logic [REL_W-1:0] count_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d          = state_q;
		count_d          = count_q;
		cmd.insert       = 1'b0;
		cmd.release_head = 1'b0;
		cmd.emit         = 1'b0;
		cmd.last         = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.insert = 1'b1;
					count_d    = '0;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.head_match) begin
						cmd.release_head = 1'b1;
						// stop at the release cap or when the next head does not follow on
						cmd.last = !st.next_match || (count_q == REL_W'(MAX_RESULTS - 1));
						if (cmd.last) begin
							state_d = S_IDLE;
						end else begin
							count_d = count_q + REL_W'(1);
						end
					end else begin
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

### rtl/sorted_release_buffer_top.sv
// Sorted release buffer.
// Input channel (value, in_valid, in_stall): one 16-bit value per beat, inserted
// into a 32-entry store kept in descending order; a value arriving while the store
// is full is dropped and flagged on every result of that beat.
// Output channel (released, release_valid, dropped, last, out_valid, out_stall):
// while the head equals the expected value it is released and the expected value
// steps down by one; an input that releases nothing gives one marker beat with
// release_valid low. The final beat of each input has last set; at most 32
// releases per input, the rest go out with the next input.
// Config channel (start_value, cfg_valid, cfg_ready): loads the expected value.
// Timing: the insert is done in S_IDLE when the input is accepted, and each result
// is then registered from S_CHECK once the output is free, the first and every
// further release alike. in_stall stays high in S_CHECK, so a new input is taken
// only after the last beat of the one before has entered the single output register.
// A stalled receiver holds the output beat and, during a release run, holds the
// controller; a new input is taken while the last beat still waits.
// Reset empties the store and clears the expected value to zero.
`default_nettype none

module sorted_release_buffer_top
	import srb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [VAL_W-1:0] value,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [VAL_W-1:0] start_value,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [VAL_W-1:0]      released,
	output logic                  release_valid,
	output logic                  dropped,
	output logic                  last
);

	srb_cmd_t    cmd;
	srb_status_t st;

	assign cfg_ready = 1'b1;

	srb_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	srb_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.value         (value),
		.cfg_we        (cfg_valid && cfg_ready),
		.start_value   (start_value),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.released      (released),
		.release_valid (release_valid),
		.dropped       (dropped),
		.last          (last)
	);

endmodule

`default_nettype wire
